[rtl/npwt_pkg.sv]
// ----------------------------------------------------------------------------
// npwt_pkg
// Shared types and constants for the nearest point within tolerance lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package npwt_pkg;

   // Table sizes
   localparam int PRIM_DEPTH = 256;
   localparam int SEC_DEPTH  = 1024;

   localparam int PRIM_AW = (PRIM_DEPTH > 1) ? $clog2(PRIM_DEPTH) : 1;
   localparam int SEC_AW  = (SEC_DEPTH > 1) ? $clog2(SEC_DEPTH) : 1;
   localparam int PRIM_CW = $clog2(PRIM_DEPTH + 1);
   localparam int SEC_CW  = $clog2(SEC_DEPTH + 1);
   localparam int SCAN_CW = (PRIM_CW > SEC_CW) ? PRIM_CW : SEC_CW;

   // Field widths
   localparam int OP_W    = 2;
   localparam int KIND_W  = 2;
   localparam int COORD_W = 24;
   localparam int ROT_W   = 16;
   localparam int ID_W    = 16;
   localparam int TOL_W   = 50;
   localparam int SQ_W    = 2 * COORD_W;
   localparam int DIST_W  = SQ_W + 2;

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(65536);

   // Stream widths
   localparam int REQ_TDATA_W = 144;
   localparam int RSP_TDATA_W = 72;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR    = 2'd0,
      OP_ADD_PRIM = 2'd1,
      OP_ADD_SEC  = 2'd2,
      OP_QUERY    = 2'd3
   } opcode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE = 2'd0,
      KIND_PRIM = 2'd1,
      KIND_SEC  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIM_SCAN,
      ST_PRIM_DRAIN,
      ST_SEC_SCAN,
      ST_SEC_DRAIN,
      ST_FINISH
   } state_type;

   // One point, as it arrives and as it is stored (last field in the low bits)
   typedef struct packed {
      logic [ID_W-1:0]    template_id;
      logic               has_rot;
      logic [ROT_W-1:0]   rot_z;
      logic [ROT_W-1:0]   rot_y;
      logic [ROT_W-1:0]   rot_x;
      logic [COORD_W-1:0] pos_z;
      logic [COORD_W-1:0] pos_y;
      logic [COORD_W-1:0] pos_x;
   } point_type;

   // Result payload without the kind
   typedef struct packed {
      logic               has_rot;
      logic [ROT_W-1:0]   rot_z;
      logic [ROT_W-1:0]   rot_y;
      logic [ROT_W-1:0]   rot_x;
      logic [ID_W-1:0]    id;
   } match_type;

   // Controller to datapath
   typedef struct packed {
      logic clear;
      logic append_prim;
      logic append_sec;
      logic query_start;
      logic issue_prim;
      logic sec_start;
      logic issue_sec;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic prim_done;
      logic sec_done;
      logic pipe_busy;
      logic hit;
      logic rsp_busy;
   } status_type;

endpackage

`default_nettype wire

[rtl/npwt_ctrl.sv]
// ----------------------------------------------------------------------------
// npwt_ctrl
// Sequencer: decodes requests, steps the table scans and hands off results.
// ----------------------------------------------------------------------------
`default_nettype none

module npwt_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [npwt_pkg::OP_W-1:0] req_opcode,
   input  npwt_pkg::status_type      status,
   output npwt_pkg::cmd_type         cmd
);
   import npwt_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (opcode_type'(req_opcode))
                  OP_CLEAR:    cmd.clear       = 1'b1;
                  OP_ADD_PRIM: cmd.append_prim = 1'b1;
                  OP_ADD_SEC:  cmd.append_sec  = 1'b1;
                  OP_QUERY: begin
                     cmd.query_start = 1'b1;
                     state_in        = ST_PRIM_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_PRIM_SCAN: begin
            cmd.issue_prim = 1'b1;
            if (status.prim_done) begin
               state_in = ST_PRIM_DRAIN;
            end
         end
         ST_PRIM_DRAIN: begin
            if (!status.pipe_busy) begin
               if (status.hit) begin
                  state_in = ST_FINISH;
               end else begin
                  cmd.sec_start = 1'b1;
                  state_in      = ST_SEC_SCAN;
               end
            end
         end
         ST_SEC_SCAN: begin
            cmd.issue_sec = 1'b1;
            if (status.sec_done) begin
               state_in = ST_SEC_DRAIN;
            end
         end
         ST_SEC_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait for the output register to free up
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

[rtl/npwt_dpath.sv]
// ----------------------------------------------------------------------------
// npwt_dpath
// Point tables, squared distance pipeline, best-match tracking and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module npwt_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  npwt_pkg::cmd_type            cmd,
   output npwt_pkg::status_type         status,
   input  npwt_pkg::point_type          req_point,
   input  logic                         csr_valid,
   input  logic [npwt_pkg::TOL_W-1:0]   csr_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [npwt_pkg::KIND_W-1:0]  rsp_kind,
   output npwt_pkg::match_type          rsp_match
);
   import npwt_pkg::*;

   // |a - b| of two signed coordinates; always fits the coordinate width
   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      logic [COORD_W:0] d;
      logic [COORD_W:0] nd;
      d  = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      nd = ~d + 1'b1;
      return d[COORD_W] ? nd[COORD_W-1:0] : d[COORD_W-1:0];
   endfunction

   // Tolerance register
   logic [TOL_W-1:0] tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_valid) begin
         tol_ff <= csr_data;
      end
   end

   // Fill counts
   logic [PRIM_CW-1:0] prim_count_ff;
   logic [SEC_CW-1:0]  sec_count_ff;
   logic               prim_we;
   logic               sec_we;

   assign prim_we = cmd.append_prim && (prim_count_ff < PRIM_CW'(PRIM_DEPTH));
   assign sec_we  = cmd.append_sec && (sec_count_ff < SEC_CW'(SEC_DEPTH));

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         prim_count_ff <= '0;
         sec_count_ff  <= '0;
      end else begin
         if (prim_we) prim_count_ff <= prim_count_ff + 1'b1;
         if (sec_we)  sec_count_ff  <= sec_count_ff + 1'b1;
      end
   end

   // Scan index, shared by both tables
   logic [SCAN_CW-1:0] scan_idx_ff;
   logic               prim_re;
   logic               sec_re;

   assign status.prim_done = scan_idx_ff >= SCAN_CW'(prim_count_ff);
   assign status.sec_done  = scan_idx_ff >= SCAN_CW'(sec_count_ff);
   assign prim_re = cmd.issue_prim && !status.prim_done;
   assign sec_re  = cmd.issue_sec && !status.sec_done;

   always_ff @(posedge clock) begin
      if (cmd.query_start || cmd.sec_start) begin
         scan_idx_ff <= '0;
      end else if (prim_re || sec_re) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
   end

   // Stored point for an append; primary entries always carry a rotation
   point_type wr_point;

   always_comb begin
      wr_point = req_point;
      if (cmd.append_prim) wr_point.has_rot = 1'b1;
   end

   // Point memories, registered read
   point_type prim_mem [PRIM_DEPTH];
   point_type sec_mem  [SEC_DEPTH];
   point_type prim_rd_ff;
   point_type sec_rd_ff;

   always_ff @(posedge clock) begin
      if (prim_we) prim_mem[prim_count_ff[PRIM_AW-1:0]] <= wr_point;
      if (prim_re) prim_rd_ff <= prim_mem[scan_idx_ff[PRIM_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (sec_we) sec_mem[sec_count_ff[SEC_AW-1:0]] <= wr_point;
      if (sec_re) sec_rd_ff <= sec_mem[scan_idx_ff[SEC_AW-1:0]];
   end

   // Query point
   logic [COORD_W-1:0] qx_ff;
   logic [COORD_W-1:0] qy_ff;
   logic [COORD_W-1:0] qz_ff;

   always_ff @(posedge clock) begin
      if (cmd.query_start) begin
         qx_ff <= req_point.pos_x;
         qy_ff <= req_point.pos_y;
         qz_ff <= req_point.pos_z;
      end
   end

   // Pipeline valid bits and table tags (tag high = secondary)
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic t1_ff, t2_ff, t3_ff, t4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= prim_re || sec_re;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign status.pipe_busy = v1_ff || v2_ff || v3_ff || v4_ff;

   // Stage 2: absolute differences
   point_type          entry1;
   logic [COORD_W-1:0] ad_x_ff;
   logic [COORD_W-1:0] ad_y_ff;
   logic [COORD_W-1:0] ad_z_ff;
   match_type          m2_ff, m3_ff, m4_ff;

   assign entry1 = t1_ff ? sec_rd_ff : prim_rd_ff;

   always_ff @(posedge clock) begin
      t1_ff   <= sec_re;
      ad_x_ff <= abs_diff(entry1.pos_x, qx_ff);
      ad_y_ff <= abs_diff(entry1.pos_y, qy_ff);
      ad_z_ff <= abs_diff(entry1.pos_z, qz_ff);
      t2_ff   <= t1_ff;
      m2_ff   <= '{has_rot: entry1.has_rot, rot_z: entry1.rot_z, rot_y: entry1.rot_y,
                   rot_x: entry1.rot_x, id: entry1.template_id};
   end

   // Stage 3: squares
   logic [SQ_W-1:0] sq_x_ff;
   logic [SQ_W-1:0] sq_y_ff;
   logic [SQ_W-1:0] sq_z_ff;

   always_ff @(posedge clock) begin
      sq_x_ff <= SQ_W'(ad_x_ff) * SQ_W'(ad_x_ff);
      sq_y_ff <= SQ_W'(ad_y_ff) * SQ_W'(ad_y_ff);
      sq_z_ff <= SQ_W'(ad_z_ff) * SQ_W'(ad_z_ff);
      t3_ff   <= t2_ff;
      m3_ff   <= m2_ff;
   end

   // Stage 4: sum
   logic [DIST_W-1:0] dist_ff;

   always_ff @(posedge clock) begin
      dist_ff <= DIST_W'(sq_x_ff) + DIST_W'(sq_y_ff) + DIST_W'(sq_z_ff);
      t4_ff   <= t3_ff;
      m4_ff   <= m3_ff;
   end

   // Best match so far; ties take the later entry
   logic [DIST_W-1:0] best_ff;
   kind_type          kind_ff;
   match_type         sel_ff;

   always_ff @(posedge clock) begin
      if (cmd.query_start) begin
         best_ff <= DIST_W'(tol_ff);
         kind_ff <= KIND_NONE;
         sel_ff  <= '0;
      end else if (v4_ff && (dist_ff <= best_ff)) begin
         best_ff <= dist_ff;
         kind_ff <= t4_ff ? KIND_SEC : KIND_PRIM;
         sel_ff  <= m4_ff;
      end
   end

   assign status.hit = (kind_ff != KIND_NONE);

   // Result register
   logic      rsp_valid_ff;
   kind_type  rsp_kind_ff;
   match_type rsp_match_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_kind_ff  <= kind_ff;
         rsp_match_ff <= sel_ff;
      end
   end

   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_match       = rsp_match_ff;

endmodule

`default_nettype wire

[rtl/nearest_point_within_tolerance.sv]
// ----------------------------------------------------------------------------
// nearest_point_within_tolerance
// Fixed-radius nearest point lookup over a primary and a secondary point table.
// ----------------------------------------------------------------------------
// Clear, append-primary and append-secondary requests complete at their
// transfer. A query scans the primary table one entry per cycle through a
// five-stage distance pipeline (memory read, difference, square, sum,
// compare); the single read port of each table memory sets that pace. When the
// primary table holds no hit, the secondary table is scanned the same way
// after the primary distances have drained. The result turns valid and the next
// request can be taken once any previous result has left the output register.
// No new request is taken while a query is in flight, but one finished result
// may wait in the output register while further requests are accepted. The
// tolerance register is written through csr_valid/csr_data and is always
// ready; it holds squared distance in squared Q16.8 units.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_point_within_tolerance (
   input  logic                                  clock,
   input  logic                                  reset,
   // request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // pos_x[23:0] pos_y[47:24] pos_z[71:48] rot_x[87:72] rot_y[103:88]
   // rot_z[119:104] has_rot_in[120] template_id[136:121], zero above
   input  logic [npwt_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // opcode[1:0]
   input  logic [npwt_pkg::OP_W-1:0]             req_tuser,
   // result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // match_id[15:0] match_rot_x[31:16] match_rot_y[47:32] match_rot_z[63:48]
   // match_has_rot[64], zero above
   output logic [npwt_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // match_kind[1:0]
   output logic [npwt_pkg::KIND_W-1:0]           rsp_tuser,
   // tolerance register write
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [npwt_pkg::TOL_W-1:0]            csr_data
);
   import npwt_pkg::*;

   localparam int RSP_PAD_W = RSP_TDATA_W - $bits(match_type);

   cmd_type    cmd;
   status_type status;
   point_type  req_point;
   match_type  rsp_match;

   // Unpack request, pack result
   assign req_point = point_type'(req_tdata[$bits(point_type)-1:0]);
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_match};
   assign csr_ready = 1'b1;

   npwt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   npwt_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_point (req_point),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_kind  (rsp_tuser),
      .rsp_match (rsp_match)
   );

   // No request is taken while distances are still in the pipeline
   a_busy_blocks_req : assert property (@(posedge clock) disable iff (reset)
      status.pipe_busy |-> !req_tready)
      else $error("request accepted during a scan");

   // A miss reports an all-zero payload
   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_NONE) |-> (rsp_tdata == '0))
      else $error("miss with nonzero payload");

   // Primary hits always carry a rotation
   a_prim_rot : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_PRIM) |-> rsp_tdata[$bits(match_type)-1])
      else $error("primary hit without rotation");

   // A new result only appears at the end of a query
   a_rsp_after_query : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result without a finished query");

endmodule

`default_nettype wire

[tb/sv/tb_nearest_point_within_tolerance.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_point_within_tolerance
// Self-checking testbench for the two-table nearest point lookup.
// ----------------------------------------------------------------------------
// A short scripted sequence covers the field extremes, each opcode, the
// tolerance boundary, ties, primary precedence and secondary entries without
// rotation. Random phases follow under several tolerance settings, zero and
// full scale among them, with clustered points so that queries hit, plus raw
// noise. A last phase fills the primary table past capacity. Each query result
// is checked field by field against an in-bench table copy or a fixed result.
// ----------------------------------------------------------------------------
module tb_nearest_point_within_tolerance;
   import npwt_pkg::*;

   localparam int COORD_MAX      = 8388607;
   localparam int COORD_MIN      = -8388608;
   localparam int FAR_COORD      = -(1 << 22);
   localparam int SETTLE_CYCLES  = 32;
   localparam int SCAN_CYCLES    = PRIM_DEPTH + SEC_DEPTH + 32;
   localparam int TABLE_SOFT_CAP = 96;
   localparam int SCRIPT_LEN     = 20;
   localparam logic [TOL_W-1:0] TOL_MAX = '1;

   typedef struct packed {
      kind_type  kind;
      match_type body;
   } lookup_type;

   typedef struct {
      opcode_type op;
      point_type  pt;
      bit         typed;
      lookup_type want;
   } script_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [OP_W-1:0]        req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]      rsp_tuser;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [TOL_W-1:0]       csr_data;

   // Shadow copy of the block state
   point_type        prim_table [PRIM_DEPTH];
   point_type        sec_table [SEC_DEPTH];
   int               prim_fill;
   int               sec_fill;
   logic [TOL_W-1:0] tol_sq;

   // Pending results: newest at the front, oldest at the back
   lookup_type     awaited_matches [$];
   script_row_type script [SCRIPT_LEN];
   int             row_count = 0;
   point_type      cluster;
   bit             gaps_on = 1'b1;
   int             error_count;

   nearest_point_within_tolerance dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------
   function automatic longint unsigned dist_sq(point_type a, point_type b);
      longint dx, dy, dz;
      dx = longint'($signed(a.pos_x)) - longint'($signed(b.pos_x));
      dy = longint'($signed(a.pos_y)) - longint'($signed(b.pos_y));
      dz = longint'($signed(a.pos_z)) - longint'($signed(b.pos_z));
      return longint'(dx * dx + dy * dy + dz * dz);
   endfunction

   // Nearest entry within tolerance, later entry wins a tie, primary first
   function automatic lookup_type nearest_entry(point_type q);
      lookup_type       res;
      longint unsigned  best, d;
      res  = '0;
      best = longint'(tol_sq);
      for (int i = 0; i < prim_fill; i++) begin
         d = dist_sq(prim_table[i], q);
         if (d <= best) begin
            best              = d;
            res.kind          = KIND_PRIM;
            res.body.id       = prim_table[i].template_id;
            res.body.rot_x    = prim_table[i].rot_x;
            res.body.rot_y    = prim_table[i].rot_y;
            res.body.rot_z    = prim_table[i].rot_z;
            res.body.has_rot  = 1'b1;
         end
      end
      if (res.kind == KIND_NONE) begin
         for (int i = 0; i < sec_fill; i++) begin
            d = dist_sq(sec_table[i], q);
            if (d <= best) begin
               best              = d;
               res.kind          = KIND_SEC;
               res.body.id       = sec_table[i].template_id;
               res.body.rot_x    = sec_table[i].rot_x;
               res.body.rot_y    = sec_table[i].rot_y;
               res.body.rot_z    = sec_table[i].rot_z;
               res.body.has_rot  = sec_table[i].has_rot;
            end
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic point_type mk_point(int x, int y, int z, int rx, int ry, int rz,
                                          bit hr, int id);
      point_type pt;
      pt.pos_x       = COORD_W'(x);
      pt.pos_y       = COORD_W'(y);
      pt.pos_z       = COORD_W'(z);
      pt.rot_x       = ROT_W'(rx);
      pt.rot_y       = ROT_W'(ry);
      pt.rot_z       = ROT_W'(rz);
      pt.has_rot     = hr;
      pt.template_id = ID_W'(id);
      return pt;
   endfunction

   function automatic lookup_type mk_result(kind_type kind, int id, int rx, int ry, int rz,
                                            bit hr);
      lookup_type res;
      res.kind         = kind;
      res.body.id      = ID_W'(id);
      res.body.rot_x   = ROT_W'(rx);
      res.body.rot_y   = ROT_W'(ry);
      res.body.rot_z   = ROT_W'(rz);
      res.body.has_rot = hr;
      return res;
   endfunction

   function automatic point_type random_point();
      logic [159:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      return raw[$bits(point_type)-1:0];
   endfunction

   function automatic logic [COORD_W-1:0] jitter(int span);
      return COORD_W'(int'($urandom_range(2 * span)) - span);
   endfunction

   // Position pt around base, keeping its rotation, flag and id
   function automatic point_type moved(point_type pt, point_type base, int span);
      pt.pos_x = base.pos_x + jitter(span);
      pt.pos_y = base.pos_y + jitter(span);
      pt.pos_z = base.pos_z + jitter(span);
      return pt;
   endfunction

   // Some entry already stored in either table; caller makes sure one exists
   function automatic point_type stored_point();
      if (sec_fill == 0 || (prim_fill != 0 && $urandom_range(1) == 1))
         return prim_table[$urandom_range(prim_fill - 1)];
      return sec_table[$urandom_range(sec_fill - 1)];
   endfunction

   // One row of the scripted part
   task automatic add_row(opcode_type op, point_type pt, bit typed, lookup_type want);
      script[row_count].op    = op;
      script[row_count].pt    = pt;
      script[row_count].typed = typed;
      script[row_count].want  = want;
      row_count++;
   endtask

   // ---------------------------------------------------------------------
   // Request side: one transfer, then shadow update or expected result
   // ---------------------------------------------------------------------
   task automatic issue(opcode_type op, point_type pt, bit typed, lookup_type want);
      while (gaps_on && $urandom_range(99) < 11) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_TDATA_W'(pt);
      do @(posedge clock); while (!req_tready);
      case (op)
         OP_CLEAR: begin
            prim_fill = 0;
            sec_fill  = 0;
         end
         OP_ADD_PRIM: begin
            if (prim_fill < PRIM_DEPTH) begin
               prim_table[prim_fill] = pt;
               prim_fill++;
            end
         end
         OP_ADD_SEC: begin
            if (sec_fill < SEC_DEPTH) begin
               sec_table[sec_fill] = pt;
               sec_fill++;
            end
         end
         default: awaited_matches.push_front(typed ? want : nearest_entry(pt));
      endcase
   endtask

   // Stop sending and let every pending query come back
   task automatic wait_for_results(int settle);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited_matches.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [TOL_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tol_sq = value;
   endtask

   // Mostly clustered appends and queries near stored points, some raw noise
   task automatic run_random(int n_items, int span);
      point_type  pt;
      opcode_type op;
      int         pick;
      for (int n = 0; n < n_items; n++) begin
         pick = $urandom_range(99);
         pt   = random_point();
         if (prim_fill + sec_fill >= TABLE_SOFT_CAP || pick < 3) begin
            op      = OP_CLEAR;
            cluster = random_point();
         end else if (pick < 13) begin
            op = opcode_type'($urandom_range(3));
         end else if (pick < 58) begin
            op = ($urandom_range(1) == 1) ? OP_ADD_PRIM : OP_ADD_SEC;
            if (prim_fill + sec_fill > 0 && $urandom_range(9) == 0)
               pt = moved(pt, stored_point(), 0);
            else
               pt = moved(pt, cluster, span);
         end else begin
            op = OP_QUERY;
            if (prim_fill + sec_fill > 0 && $urandom_range(3) != 0)
               pt = moved(pt, stored_point(), ($urandom_range(1) == 1) ? 0 : span);
            else
               pt = moved(pt, cluster, span);
         end
         if ($urandom_range(99) < 2)
            wait_for_results(0);
         issue(op, pt, 1'b0, '0);
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------
   task automatic flag_error(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
         flag_error(name, got, want);
   endtask

   always @(posedge clock)
      rsp_tready <= !(gaps_on && $urandom_range(99) < 11);

   // Compare each result transfer with the oldest pending query
   always @(posedge clock) begin : result_check
      match_type  seen;
      lookup_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata[$bits(match_type)-1:0];
         if (awaited_matches.size() == 0) begin
            flag_error("result with no query pending", rsp_tuser, 0);
         end else begin
            want = awaited_matches.pop_back();
            check_field("match_kind", rsp_tuser, want.kind);
            check_field("match_id", seen.id, want.body.id);
            check_field("match_rot_x", seen.rot_x, want.body.rot_x);
            check_field("match_rot_y", seen.rot_y, want.body.rot_y);
            check_field("match_rot_z", seen.rot_z, want.body.rot_z);
            check_field("match_has_rot", seen.has_rot, want.body.has_rot);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      point_type  pt;
      lookup_type no_hit;
      int         r;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_CLEAR;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      tol_sq     = TOL_RESET;
      cluster    = '0;
      no_hit     = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Scripted part, reset tolerance (radius 1.0)
      add_row(OP_QUERY, mk_point(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, no_hit);
      add_row(OP_ADD_PRIM, mk_point(COORD_MAX, COORD_MAX, COORD_MAX,
              16'h7FFF, 16'h8000, 16'h1234, 1'b0, 16'hFFFF), 1'b0, no_hit);
      add_row(OP_QUERY, mk_point(COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, 0, 0),
              1'b1, mk_result(KIND_PRIM, 16'hFFFF, 16'h7FFF, 16'h8000,
              16'h1234, 1'b1));
      // secondary entry without rotation still reports its rotation bits
      add_row(OP_ADD_SEC, mk_point(COORD_MIN, COORD_MIN, COORD_MIN,
              16'hAAAA, 16'h5555, 16'hFFFF, 1'b0, 16'h8001), 1'b0, no_hit);
      add_row(OP_QUERY, mk_point(COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0, 1, 0),
              1'b1, mk_result(KIND_SEC, 16'h8001, 16'hAAAA, 16'h5555,
              16'hFFFF, 1'b0));
      // distance exactly at the bound, then one step past it
      add_row(OP_ADD_SEC, mk_point(256, 0, 0, 1, 2, 3, 1'b1, 0), 1'b0, no_hit);
      add_row(OP_QUERY, mk_point(0, 0, 0, 0, 0, 0, 0, 0), 1'b0, no_hit);
      add_row(OP_QUERY, mk_point(-1, 0, 0, 0, 0, 0, 0, 0), 1'b0, no_hit);
      // tie goes to the later entry, nearer entry wins
      add_row(OP_ADD_PRIM, mk_point(10, 10, 10, 7, 8, 9, 1'b1, 2), 1'b0, no_hit);
      add_row(OP_ADD_PRIM, mk_point(10, 10, 10, 4, 5, 6, 1'b0, 3), 1'b0, no_hit);
      add_row(OP_QUERY, mk_point(10, 10, 10, 0, 0, 0, 0, 0), 1'b0, no_hit);
      add_row(OP_ADD_PRIM, mk_point(5, 10, 10, -1, -2, -3, 1'b1, 4), 1'b0, no_hit);
      add_row(OP_QUERY, mk_point(6, 10, 10, 0, 0, 0, 0, 0), 1'b0, no_hit);
      // primary hit wins over a nearer secondary entry
      add_row(OP_ADD_SEC, mk_point(200, 10, 10, 11, 12, 13, 1'b1, 5), 1'b0, no_hit);
      add_row(OP_QUERY, mk_point(200, 10, 10, 0, 0, 0, 0, 0), 1'b0, no_hit);
      add_row(OP_CLEAR, mk_point(0, 0, 0, 0, 0, 0, 0, 0), 1'b0, no_hit);
      add_row(OP_QUERY, mk_point(10, 10, 10, 0, 0, 0, 0, 0), 1'b1, no_hit);
      add_row(OP_ADD_PRIM, mk_point(COORD_MIN, COORD_MIN, COORD_MIN,
              16'h8000, 16'h8000, 16'h8000, 1'b1, 0), 1'b0, no_hit);
      add_row(OP_QUERY, mk_point(COORD_MIN, COORD_MIN, COORD_MIN + 256,
              0, 0, 0, 0, 0), 1'b0, no_hit);
      // largest possible distance, far outside the bound
      add_row(OP_QUERY, mk_point(COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, 0, 0),
              1'b1, no_hit);
      for (int i = 0; i < row_count; i++)
         issue(script[i].op, script[i].pt, script[i].typed, script[i].want);
      wait_for_results(SETTLE_CYCLES);

      // Exact matches only
      write_tolerance('0);
      run_random(30, 2);
      wait_for_results(SETTLE_CYCLES);

      // Every stored point is in range
      write_tolerance(TOL_MAX);
      run_random(25, 1 << 20);
      wait_for_results(SETTLE_CYCLES);

      // Small radius, no idling on either side
      gaps_on = 1'b0;
      r = $urandom_range(4096, 16);
      write_tolerance(TOL_W'(longint'(r) * r));
      run_random(55, r);
      wait_for_results(SETTLE_CYCLES);
      gaps_on = 1'b1;

      // Large radius
      r = $urandom_range(1 << 22, 4096);
      write_tolerance(TOL_W'(longint'(r) * r));
      run_random(35, r);
      wait_for_results(SETTLE_CYCLES);

      write_tolerance(TOL_RESET);
      run_random(28, 256);
      wait_for_results(SETTLE_CYCLES);

      // Fill the primary table; three more appends at a far spot are dropped
      issue(OP_CLEAR, random_point(), 1'b0, '0);
      for (int i = 0; i < PRIM_DEPTH + 3; i++) begin
         pt       = random_point();
         pt.pos_x = COORD_W'((i < PRIM_DEPTH) ? i * 1024 : FAR_COORD);
         pt.pos_y = '0;
         pt.pos_z = '0;
         issue(OP_ADD_PRIM, pt, 1'b0, '0);
      end
      issue(OP_QUERY, mk_point(0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      issue(OP_QUERY, mk_point((PRIM_DEPTH - 1) * 1024, 0, 100, 0, 0, 0, 0, 0), 1'b0, '0);
      issue(OP_QUERY, mk_point(FAR_COORD, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      // tables are usable again after a clear from full
      issue(OP_CLEAR, random_point(), 1'b0, '0);
      issue(OP_QUERY, mk_point(0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      issue(OP_ADD_SEC, mk_point(3, 3, 3, 21, 22, 23, 1'b1, 77), 1'b0, '0);
      issue(OP_QUERY, mk_point(0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);

      wait_for_results(SCAN_CYCLES);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog: the slowest correct run stays well below this
   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

[nearest_point_within_tolerance.f]
rtl/npwt_pkg.sv
rtl/npwt_ctrl.sv
rtl/npwt_dpath.sv
rtl/nearest_point_within_tolerance.sv
tb/sv/tb_nearest_point_within_tolerance.sv
